### hw/rtl/wudiv_pkg.sv
`default_nettype none

package wudiv_pkg;

  localparam int QUO_W  = 96;   // quotient bits carried on the result item
  localparam int REM_W  = 32;   // remainder bits carried on the result item
  localparam int STEP_W = 3;    // microcode address width

  localparam logic [3:0] DIV_TEN = 4'd10;

  // Microcode addresses
  localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK = 3'd1;
  localparam logic [STEP_W-1:0] STEP_INIT  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_ITER  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_FIN   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_DONE  = 3'd5;

  typedef enum logic [2:0] {
    COND_ALWAYS   = 3'd0,
    COND_IN_VALID = 3'd1,
    COND_REP_ZERO = 3'd2,
    COND_BIT_LAST = 3'd3,
    COND_OUT_FREE = 3'd4
  } cond_t;

  typedef struct packed {
    logic              in_rdy;
    logic              load;
    logic              init;
    logic              shift;
    logic              finish;
    logic              emit;
    cond_t             cond;
    logic [STEP_W-1:0] jump;   // taken when cond holds
    logic [STEP_W-1:0] fall;   // taken otherwise
  } ucode_word_t;

  typedef struct packed {
    logic load;
    logic init;
    logic shift;
    logic finish;
  } dp_ctrl_t;

  typedef struct packed {
    logic rep_zero;
    logic bit_last;
  } dp_status_t;

  typedef struct packed {
    logic        mode;
    logic [63:0] dividend_lo;
    logic [31:0] dividend_hi;
    logic [63:0] divisor_lo;
    logic [31:0] divisor_hi;
    logic [4:0]  repeat_count;
  } in_item_t;

  typedef struct packed {
    logic [63:0] quotient_lo;
    logic [31:0] quotient_hi;
    logic [31:0] remainder_word;
  } out_item_t;

  // Control store
  function automatic ucode_word_t ucode(input logic [STEP_W-1:0] pc);
    ucode_word_t w;
    w = '0;
    unique case (pc)
      STEP_IDLE: begin
        w.in_rdy = 1'b1; w.load = 1'b1;
        w.cond = COND_IN_VALID; w.jump = STEP_CHECK; w.fall = STEP_IDLE;
      end
      STEP_CHECK: begin
        w.cond = COND_REP_ZERO; w.jump = STEP_DONE; w.fall = STEP_INIT;
      end
      STEP_INIT: begin
        w.init = 1'b1;
        w.cond = COND_ALWAYS; w.jump = STEP_ITER; w.fall = STEP_ITER;
      end
      STEP_ITER: begin
        w.shift = 1'b1;
        w.cond = COND_BIT_LAST; w.jump = STEP_FIN; w.fall = STEP_ITER;
      end
      STEP_FIN: begin
        w.finish = 1'b1;
        w.cond = COND_ALWAYS; w.jump = STEP_CHECK; w.fall = STEP_CHECK;
      end
      STEP_DONE: begin
        w.emit = 1'b1;
        w.cond = COND_OUT_FREE; w.jump = STEP_IDLE; w.fall = STEP_DONE;
      end
      default: begin
        w.cond = COND_ALWAYS; w.jump = STEP_IDLE; w.fall = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/wudiv_datapath.sv
`default_nettype none

module wudiv_datapath #(
  parameter int DATA_WIDTH = 96,
  parameter int MAX_REPEAT = 31
) (
  input  wire                            clk,
  input  wudiv_pkg::in_item_t            in_data,
  input  wudiv_pkg::dp_ctrl_t            ctrl,
  output wudiv_pkg::dp_status_t          status,
  output logic [wudiv_pkg::QUO_W-1:0]    quotient,
  output logic [wudiv_pkg::REM_W-1:0]    remainder_word
);
  import wudiv_pkg::*;

  localparam int XW = (DATA_WIDTH > QUO_W) ? DATA_WIDTH : QUO_W;
  localparam int ZW = (DATA_WIDTH > REM_W) ? DATA_WIDTH : REM_W;
  localparam int BW = $clog2(DATA_WIDTH);
  localparam int RW = $clog2(MAX_REPEAT + 1);

  // acc: dividend shifting out on top, quotient bits shifting in at bottom
  logic [DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH-1:0] dsr;
  logic [DATA_WIDTH-1:0] part;
  logic [BW-1:0]         bitcnt;
  logic [RW-1:0]         rep;
  logic [REM_W-1:0]      rem_q;

  logic [XW-1:0]         dvd_ext, dsr_ext, quo_ext;
  logic [ZW-1:0]         rem_ext;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH+1:0] diff;
  logic                  fits;
  logic [RW-1:0]         rep_load;

  assign dvd_ext = XW'({in_data.dividend_hi, in_data.dividend_lo});
  assign dsr_ext = XW'({in_data.divisor_hi, in_data.divisor_lo});

  assign trial = {part, acc[DATA_WIDTH-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsr};
  assign fits  = ~diff[DATA_WIDTH+1];

  always_comb begin
    if (in_data.mode == 1'b0) begin
      rep_load = RW'(1);
    end else if (int'(in_data.repeat_count) > MAX_REPEAT) begin
      rep_load = RW'(MAX_REPEAT);
    end else begin
      rep_load = RW'(in_data.repeat_count);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc   <= dvd_ext[DATA_WIDTH-1:0];
      dsr   <= in_data.mode ? DATA_WIDTH'(DIV_TEN) : dsr_ext[DATA_WIDTH-1:0];
      rep   <= rep_load;
      rem_q <= '0;
    end
    if (ctrl.init) begin
      part   <= '0;
      bitcnt <= BW'(DATA_WIDTH - 1);
    end
    if (ctrl.shift) begin
      part   <= fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
      acc    <= {acc[DATA_WIDTH-2:0], fits};
      bitcnt <= bitcnt - BW'(1);
    end
    if (ctrl.finish) begin
      rem_q <= rem_ext[REM_W-1:0];
      rep   <= rep - RW'(1);
    end
  end

  assign rem_ext = ZW'(part);
  assign quo_ext = XW'(acc);

  assign status.rep_zero = (rep == '0);
  assign status.bit_last = (bitcnt == '0);
  assign quotient        = quo_ext[QUO_W-1:0];
  assign remainder_word  = rem_q;

endmodule

`default_nettype wire

### hw/rtl/wide_unsigned_restoring_divider_core.sv
// Sequence from accept to out_valid: mode 0 runs one restoring division; mode 1 runs
//   n divisions by ten, n = repeat_count saturated at MAX_REPEAT, then emits.
// Throughput: one item at a time; the next item can be taken in the cycle after the
//   result is handed to the output register. The restoring loop sets it.
// Reset (rst, synchronous, active high) returns the sequencer to idle and
//   empties the output register; no item is taken while rst is high.
`default_nettype none

module wide_unsigned_restoring_divider_core #(
  parameter int DATA_WIDTH = 96,   // 8 .. 192
  parameter int MAX_REPEAT = 31    // 1 .. 63
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wudiv_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output wudiv_pkg::out_item_t  out_data
);
  import wudiv_pkg::*;

  // Microcoded sequencer: pc addresses the control store, each word raises
  // datapath strobes and picks the next step from one tested condition.
  logic [STEP_W-1:0] pc, pc_next;
  ucode_word_t       uw;
  dp_ctrl_t          dp_ctrl;
  dp_status_t        dp_stat;
  logic              cond_hit;
  logic              out_free;
  logic              emit;

  logic [QUO_W-1:0]  quotient;
  logic [REM_W-1:0]  rem_word;

  assign uw       = ucode(pc);
  assign out_free = ~out_valid | out_ready;
  assign in_ready = uw.in_rdy & ~rst;

  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_IN_VALID: cond_hit = in_valid;
      COND_REP_ZERO: cond_hit = dp_stat.rep_zero;
      COND_BIT_LAST: cond_hit = dp_stat.bit_last;
      COND_OUT_FREE: cond_hit = out_free;
      default:       cond_hit = 1'b1;
    endcase
    pc_next = cond_hit ? uw.jump : uw.fall;
  end

  // Strobes; load fires on an accepted item, and also on in_valid in the idle step while rst is high.
  assign dp_ctrl.load   = uw.load & in_valid;
  assign dp_ctrl.init   = uw.init;
  assign dp_ctrl.shift  = uw.shift;
  assign dp_ctrl.finish = uw.finish;
  assign emit           = uw.emit & out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  wudiv_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .MAX_REPEAT (MAX_REPEAT)
  ) u_dp (
    .clk            (clk),
    .in_data        (in_data),
    .ctrl           (dp_ctrl),
    .status         (dp_stat),
    .quotient       (quotient),
    .remainder_word (rem_word)
  );

  // Output register: decouples the result from the next item's work.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.quotient_lo    <= quotient[63:0];
      out_data.quotient_hi    <= quotient[QUO_W-1:64];
      out_data.remainder_word <= rem_word;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/wudiv_checker.sv
`default_nettype none

module wudiv_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input wudiv_pkg::out_item_t out_data
);

  // A held result stays put until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed or dropped while stalled");

  // One item in flight: an accept is followed by a busy cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an accept");

  // A new result only appears out of a busy period.
  a_emit_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised while idle");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind wide_unsigned_restoring_divider_core wudiv_checker u_wudiv_checker (.*);

`default_nettype wire
